[hdl/ole_pkg.sv]
// ----------------------------------------------------------------------------
// Ordered list engine package
// Command codes, cell control word, lookup tree entry and controller states
// shared by the cells, the lookup tree and the top level.
// ----------------------------------------------------------------------------
package ole_pkg;

    // Widths sized for the largest supported list of 4096 entries.
    localparam int IDX_W = 12;
    localparam int CNT_W = 13;
    localparam int BYTE_W = 8;

    // Fan-in of one lookup tree node and number of registered tree levels.
    localparam int GROUP = 16;
    localparam int TREE_LEVELS = 3;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_LOCATE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_GET,
        CELL_LOCATE
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CELL,
        ST_TREE,
        ST_DONE
    } state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_op_t           op;
        logic [IDX_W-1:0]   pidx;
        logic [CNT_W-1:0]   count;
        logic [BYTE_W-1:0]  value;
    } cell_ctrl_t;

    // One candidate in the lookup tree.
    typedef struct packed {
        logic               hit;
        logic [IDX_W-1:0]   idx;
        logic [BYTE_W-1:0]  data;
    } hit_t;

endpackage

[hdl/ole_cell.sv]
// ----------------------------------------------------------------------------
// Ordered list cell
// Holds one list entry, takes a neighbor's entry when the list shifts and
// flags itself as a lookup hit for get, delete and locate.
// ----------------------------------------------------------------------------
module ole_cell #(
    parameter int J = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ole_pkg::cell_ctrl_t          ctrl,
    input  logic [ole_pkg::BYTE_W-1:0]   left_data,
    input  logic [ole_pkg::BYTE_W-1:0]   right_data,
    output logic [ole_pkg::BYTE_W-1:0]   data,
    output ole_pkg::hit_t                entry
);

    localparam logic [ole_pkg::IDX_W-1:0] JI = ole_pkg::IDX_W'(J);
    localparam logic [ole_pkg::CNT_W-1:0] JC = ole_pkg::CNT_W'(J);

    logic [ole_pkg::BYTE_W-1:0] data_reg;
    logic [ole_pkg::BYTE_W-1:0] data_next;
    logic                       hit_reg;
    logic                       hit_next;
    logic [ole_pkg::BYTE_W-1:0] hold_reg;

    // The hit flag and the captured entry stay put between commands, so a
    // result that waits for the output can still be read from the tree.
    always_comb
    begin
        data_next = data_reg;
        hit_next  = hit_reg;
        case (ctrl.op)
            ole_pkg::CELL_INSERT:
            begin
                hit_next = 1'b0;
                if (JI == ctrl.pidx)
                begin
                    data_next = ctrl.value;
                end
                else if (JI > ctrl.pidx)
                begin
                    data_next = left_data;
                end
            end
            ole_pkg::CELL_DELETE:
            begin
                // The removed entry is captured before the upper part moves down.
                hit_next = (JI == ctrl.pidx);
                if (JI >= ctrl.pidx)
                begin
                    data_next = right_data;
                end
            end
            ole_pkg::CELL_GET:
            begin
                hit_next = (JI == ctrl.pidx);
            end
            ole_pkg::CELL_LOCATE:
            begin
                hit_next = (data_reg == ctrl.value) && (JC < ctrl.count);
            end
            default:
            begin
                hit_next = hit_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        if (ctrl.op != ole_pkg::CELL_HOLD)
        begin
            hold_reg <= data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg <= 1'b0;
        end
        else
        begin
            hit_reg <= hit_next;
        end
    end

    assign data       = data_reg;
    assign entry.hit  = hit_reg;
    assign entry.idx  = JI;
    assign entry.data = hold_reg;

endmodule

[hdl/ole_reduce.sv]
// ----------------------------------------------------------------------------
// Ordered list lookup tree level
// Picks the lowest-indexed hit out of each group of candidates and registers
// one candidate per group for the next level.
// ----------------------------------------------------------------------------
module ole_reduce #(
    parameter int N_IN  = 256,
    parameter int N_OUT = (N_IN + ole_pkg::GROUP - 1) / ole_pkg::GROUP
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ole_pkg::hit_t in_entry  [N_IN],
    output ole_pkg::hit_t out_entry [N_OUT]
);

    ole_pkg::hit_t sel_reg  [N_OUT];
    ole_pkg::hit_t sel_next [N_OUT];

    always_comb
    begin
        int e;
        for (int g = 0; g < N_OUT; g++)
        begin
            sel_next[g] = '0;
            // Walking from the top down lets the lowest hit win.
            for (int k = ole_pkg::GROUP - 1; k >= 0; k--)
            begin
                e = g * ole_pkg::GROUP + k;
                if (e < N_IN)
                begin
                    if (in_entry[e].hit)
                    begin
                        sel_next[g] = in_entry[e];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < N_OUT; g++)
            begin
                sel_reg[g] <= '0;
            end
        end
        else
        begin
            for (int g = 0; g < N_OUT; g++)
            begin
                sel_reg[g] <= sel_next[g];
            end
        end
    end

    assign out_entry = sel_reg;

endmodule

[hdl/ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// Ordered list engine
// Ordered list of bytes held in a row of cells, with insert, delete, get and
// locate commands and a length counter.
// ----------------------------------------------------------------------------
// Path: an accepted command word passes one cell update, three registered tree
// levels and the output register before its result word appears.
// Commands: the next command is taken only once the previous result word is
// loaded (in_stall is high until then); that word may still wait in the output register.
// Reset: the length counter and all handshake state clear at once; list
// entries are undefined until written.
// ----------------------------------------------------------------------------
module ordered_list_engine #(
    parameter int CAPACITY = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] command,
    input  logic [8:0] position,
    input  logic [7:0] value,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ok,
    output logic [7:0] item_value,
    output logic [8:0] found_position,
    output logic [8:0] length,
    output logic       empty_res
);

    localparam int CNT_W = ole_pkg::CNT_W;
    localparam int IDX_W = ole_pkg::IDX_W;
    localparam int L1N = (CAPACITY + ole_pkg::GROUP - 1) / ole_pkg::GROUP;
    localparam int L2N = (L1N + ole_pkg::GROUP - 1) / ole_pkg::GROUP;
    localparam int L3N = (L2N + ole_pkg::GROUP - 1) / ole_pkg::GROUP;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    ole_pkg::state_t           state_reg;
    ole_pkg::state_t           state_next;
    logic [1:0]                wait_reg;
    logic [1:0]                wait_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    ole_pkg::cmd_t             cmd_reg;
    ole_pkg::cmd_t             cmd_next;
    logic                      valid_op_reg;
    logic                      valid_op_next;
    logic [IDX_W-1:0]          pidx_reg;
    logic [IDX_W-1:0]          pidx_next;
    logic [7:0]                value_reg;
    logic [7:0]                value_next;

    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic                      ok_reg;
    logic                      ok_next;
    logic [7:0]                item_reg;
    logic [7:0]                item_next;
    logic [8:0]                found_reg;
    logic [8:0]                found_next;
    logic [8:0]                length_reg;
    logic [8:0]                length_next;
    logic                      empty_reg;
    logic                      empty_next;

    logic [CNT_W-1:0]          pos_ext;
    logic [IDX_W:0]            found_calc;
    ole_pkg::cell_ctrl_t       ctrl;
    ole_pkg::hit_t             lookup;

    logic [7:0]                cell_data  [CAPACITY];
    ole_pkg::hit_t             cell_entry [CAPACITY];
    ole_pkg::hit_t             lvl1       [L1N];
    ole_pkg::hit_t             lvl2       [L2N];
    ole_pkg::hit_t             lvl3       [L3N];

    // Row of cells; each sees its two neighbors for shifting.
    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        localparam int JL = (j == 0) ? 0 : j - 1;
        localparam int JR = (j == CAPACITY - 1) ? j : j + 1;

        ole_cell #(
            .J (j)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .left_data  (cell_data[JL]),
            .right_data (cell_data[JR]),
            .data       (cell_data[j]),
            .entry      (cell_entry[j])
        );
    end

    ole_reduce #(
        .N_IN  (CAPACITY),
        .N_OUT (L1N)
    ) u_lvl1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_entry  (cell_entry),
        .out_entry (lvl1)
    );

    ole_reduce #(
        .N_IN  (L1N),
        .N_OUT (L2N)
    ) u_lvl2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_entry  (lvl1),
        .out_entry (lvl2)
    );

    ole_reduce #(
        .N_IN  (L2N),
        .N_OUT (L3N)
    ) u_lvl3 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_entry  (lvl2),
        .out_entry (lvl3)
    );

    assign lookup     = lvl3[0];
    assign pos_ext    = CNT_W'(position);
    assign found_calc = {1'b0, lookup.idx} + {{IDX_W{1'b0}}, 1'b1};

    always_comb
    begin
        state_next     = state_reg;
        wait_next      = wait_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        valid_op_next  = valid_op_reg;
        pidx_next      = pidx_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg;
        ok_next        = ok_reg;
        item_next      = item_reg;
        found_next     = found_reg;
        length_next    = length_reg;
        empty_next     = empty_reg;

        ctrl.op    = ole_pkg::CELL_HOLD;
        ctrl.pidx  = pidx_reg;
        ctrl.count = count_reg;
        ctrl.value = value_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ole_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = ole_pkg::cmd_t'(command);
                    value_next = value;
                    pidx_next  = IDX_W'(pos_ext - CNT_W'(1));
                    case (ole_pkg::cmd_t'(command))
                        ole_pkg::CMD_INSERT:
                        begin
                            valid_op_next = (count_reg < CAP_C) && (pos_ext != '0)
                                && (pos_ext <= count_reg + CNT_W'(1));
                        end
                        ole_pkg::CMD_DELETE, ole_pkg::CMD_GET:
                        begin
                            valid_op_next = (pos_ext != '0) && (pos_ext <= count_reg);
                        end
                        default:
                        begin
                            valid_op_next = 1'b1;
                        end
                    endcase
                    state_next = ole_pkg::ST_CELL;
                end
            end
            ole_pkg::ST_CELL:
            begin
                if (valid_op_reg)
                begin
                    case (cmd_reg)
                        ole_pkg::CMD_INSERT:
                        begin
                            ctrl.op    = ole_pkg::CELL_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                        ole_pkg::CMD_DELETE:
                        begin
                            ctrl.op    = ole_pkg::CELL_DELETE;
                            count_next = count_reg - CNT_W'(1);
                        end
                        ole_pkg::CMD_GET:
                        begin
                            ctrl.op = ole_pkg::CELL_GET;
                        end
                        default:
                        begin
                            ctrl.op = ole_pkg::CELL_LOCATE;
                        end
                    endcase
                end
                wait_next  = 2'd0;
                state_next = ole_pkg::ST_TREE;
            end
            ole_pkg::ST_TREE:
            begin
                if (wait_reg == 2'(ole_pkg::TREE_LEVELS - 1))
                begin
                    state_next = ole_pkg::ST_DONE;
                end
                else
                begin
                    wait_next = wait_reg + 2'd1;
                end
            end
            ole_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = valid_op_reg;
                    item_next      = 8'd0;
                    found_next     = 9'd0;
                    if (valid_op_reg && lookup.hit)
                    begin
                        if (cmd_reg == ole_pkg::CMD_GET || cmd_reg == ole_pkg::CMD_DELETE)
                        begin
                            item_next = lookup.data;
                        end
                        else if (cmd_reg == ole_pkg::CMD_LOCATE)
                        begin
                            found_next = found_calc[8:0];
                        end
                    end
                    length_next = count_reg[8:0];
                    empty_next  = (count_reg == '0);
                    state_next  = ole_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ole_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ole_pkg::ST_IDLE;
            wait_reg      <= 2'd0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        valid_op_reg <= valid_op_next;
        pidx_reg     <= pidx_next;
        value_reg    <= value_next;
        ok_reg       <= ok_next;
        item_reg     <= item_next;
        found_reg    <= found_next;
        length_reg   <= length_next;
        empty_reg    <= empty_next;
    end

    assign in_stall       = (state_reg != ole_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign ok             = ok_reg;
    assign item_value     = item_reg;
    assign found_position = found_reg;
    assign length         = length_reg;
    assign empty_res      = empty_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("list length above capacity");

    a_count_only_in_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ole_pkg::ST_CELL) |=> $stable(count_reg))
        else $error("list length changed outside the cell update cycle");

    a_accept_starts_cell: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ole_pkg::ST_CELL))
        else $error("accepted word did not start a cell update");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && state_reg == ole_pkg::ST_DONE)
        |=> (state_reg == ole_pkg::ST_DONE))
        else $error("result left the controller while the output was stalled");
`endif

endmodule
